@@ design/ptrs_pkg.sv @@
// shared types and constants for the periodic task release scheduler
// no dependencies; imported by ptrs_cell, ptrs_div and the top level
`default_nettype none

package ptrs_pkg;

    localparam int TASKS_DEF   = 16;
    localparam int TICK_MS_DEF = 1;

    localparam int TIME_W = 32;
    localparam int IDX_W  = 4;
    localparam int MASK_W = 16;

    typedef enum logic [1:0] {
        FUNC_TICK,
        FUNC_LOAD,
        FUNC_SUSPEND,
        FUNC_SLEEP
    } ptrs_func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_DONE
    } ptrs_state_t;

    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] period;
    } slot_t;

endpackage

`default_nettype wire

@@ design/ptrs_cell.sv @@
// one slot of the rotating slot ring
// depends on ptrs_pkg for the slot record
`default_nettype none

module ptrs_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          shift,
    input  wire ptrs_pkg::slot_t din,
    output ptrs_pkg::slot_t    dout
);
    import ptrs_pkg::*;

    slot_t slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (shift)
        begin
            slot_reg <= din;
        end
    end

    assign dout = slot_reg;

endmodule

`default_nettype wire

@@ design/ptrs_div.sv @@
// division by the constant tick length as a multiply with its rounded-up reciprocal
// depends on ptrs_pkg for the time width
`default_nettype none

module ptrs_div #(
    parameter int TICK_MS = ptrs_pkg::TICK_MS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [ptrs_pkg::TIME_W-1:0] dividend,
    output logic                             done,
    output logic [ptrs_pkg::TIME_W-1:0]      quotient
);
    import ptrs_pkg::*;

    // reciprocal ceil(2^SHIFT / TICK_MS) is exact for every 32-bit dividend
    localparam int LG    = $clog2(TICK_MS);
    localparam int SHIFT = TIME_W + LG;
    localparam int MW    = TIME_W + 1;
    localparam int PW    = TIME_W + MW;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic              done_reg;
    logic [TIME_W-1:0] quo_reg;
    logic [PW-1:0]     prod;

    always_comb
    begin
        prod = {{MW{1'b0}}, dividend} * {{TIME_W{1'b0}}, RECIP};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= TIME_W'(prod >> SHIFT);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

@@ design/periodic_task_release_scheduler_top.sv @@
// top level of the periodic task release scheduler: control sequencer and slot ring
// depends on ptrs_pkg, ptrs_cell and ptrs_div
`default_nettype none

// The scheduler keeps TASKS periodic slots (countdown, period in ticks, running bit)
// in a ring of cells rotating one slot per cycle when walked. Each transaction on the
// input stream is one command, selected by s_tuser: tick, load, suspend or sleep.
// A tick walks the whole ring; every running slot whose countdown is zero is
// released (its bit goes into fire_mask) and reloads from its period, a zero
// period acting as one, and then every running slot counts down by one. Load,
// suspend and sleep act on the slot named by task_index while the ring passes
// it; an index at or beyond TASKS is ignored. Load and sleep first turn
// milliseconds into ticks by a multiply with the reciprocal of TICK_MS; sleep
// saturates the countdown at all ones. Every command yields exactly one output
// transaction, whose fire_mask is zero for anything but a tick. The block works on
// one command at a time: the next command can be taken only after the ring walk of
// one slot per cycle; load, suspend and sleep first pass through the registered
// reciprocal multiply.
// The result sits in an output register, so a stalled output holds back the next
// command only once the following result is also ready. Slots above fifteen are
// never addressable and never show in fire_mask.
module periodic_task_release_scheduler_top #(
    parameter int TASKS   = ptrs_pkg::TASKS_DEF,
    parameter int TICK_MS = ptrs_pkg::TICK_MS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command side
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // task_index[3:0], time_ms[35:4], delay_ticks[67:36], zeros
    input  wire logic [1:0]  s_tuser,   // func[1:0]
    // result side
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // fire_mask[15:0]
);
    import ptrs_pkg::*;

    localparam int KW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam logic [KW-1:0] K_LAST = KW'(TASKS - 1);

    // control and command registers
    ptrs_state_t       state_reg, state_next;
    logic [KW-1:0]     k_reg, k_next;          // slot currently at the head of the ring
    logic [MASK_W-1:0] mask_reg, mask_next;
    ptrs_func_t        func_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TIME_W-1:0] delay_reg;

    // output register
    logic              out_valid_reg;
    logic [MASK_W-1:0] out_mask_reg;

    logic accept;
    logic out_load;
    logic div_start;
    logic div_done;
    logic [TIME_W-1:0] ticks;

    // slot ring
    slot_t ring_q [TASKS];
    slot_t head;
    slot_t head_new;
    logic  fire;
    logic  hit;
    logic  ring_shift;
    logic [TIME_W:0] sleep_sum;

    assign accept     = s_tvalid && s_tready;
    assign div_start  = accept && (ptrs_func_t'(s_tuser) != FUNC_TICK);
    assign ring_shift = (state_reg == ST_SCAN);
    assign out_load   = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    ptrs_div #(
        .TICK_MS (TICK_MS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (s_tdata[35:4]),
        .done     (div_done),
        .quotient (ticks)
    );

    // cell i takes from cell i+1; the last cell takes the updated head slot
    genvar gi;
    generate
        for (gi = 0; gi < TASKS; gi++)
        begin : g_ring
            if (gi == TASKS - 1)
            begin : g_tail
                ptrs_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_shift),
                    .din   (head_new),
                    .dout  (ring_q[gi])
                );
            end
            else
            begin : g_body
                ptrs_cell u_cell (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .shift (ring_shift),
                    .din   (ring_q[gi+1]),
                    .dout  (ring_q[gi])
                );
            end
        end
    endgenerate

    assign head = ring_q[0];

    // update of the slot at the head of the ring
    always_comb
    begin
        head_new  = head;
        fire      = 1'b0;
        hit       = ({3'b000, idx_reg} == 7'(k_reg));
        sleep_sum = {1'b0, head.countdown} + {1'b0, ticks};
        case (func_reg)
            FUNC_TICK:
            begin
                if (head.running)
                begin
                    fire = (head.countdown == '0);
                    if (fire)
                    begin
                        // reload then count down; a zero period behaves as one
                        head_new.countdown = (head.period == '0) ? '0
                                                                 : head.period - 32'd1;
                    end
                    else
                    begin
                        head_new.countdown = head.countdown - 32'd1;
                    end
                end
            end
            FUNC_LOAD:
            begin
                if (hit)
                begin
                    head_new.period    = ticks;
                    head_new.countdown = delay_reg;
                    head_new.running   = 1'b1;
                end
            end
            FUNC_SUSPEND:
            begin
                if (hit)
                begin
                    head_new.running = 1'b0;
                end
            end
            FUNC_SLEEP:
            begin
                if (hit)
                begin
                    // saturate at all ones on overflow
                    head_new.countdown = sleep_sum[TIME_W] ? '1 : sleep_sum[TIME_W-1:0];
                end
            end
            default:
            begin
                head_new = head;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        mask_next  = mask_reg;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    k_next    = '0;
                    mask_next = '0;
                    state_next = (ptrs_func_t'(s_tuser) == FUNC_TICK) ? ST_SCAN : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // bits for slots above fifteen shift out of the mask
                mask_next = mask_reg | (fire ? (MASK_W'(1) << k_reg) : '0);
                if (k_reg == K_LAST)
                begin
                    k_next     = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            mask_reg  <= mask_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= ptrs_func_t'(s_tuser);
            idx_reg   <= s_tdata[3:0];
            delay_reg <= s_tdata[67:36];
        end
        if (out_load)
        begin
            out_mask_reg <= mask_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_mask_reg;

`ifndef SYNTHESIS
    // anything but a tick leaves an empty fire mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && func_reg != FUNC_TICK) |-> (mask_reg == '0))
        else $error("non-tick command produced a nonzero fire mask");

    // an accepted tick starts the ring walk at slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == FUNC_TICK) |=> (state_reg == ST_SCAN && k_reg == '0))
        else $error("tick did not start the ring walk at slot zero");

    // the divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide state");

    // the head index never runs past the last slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (k_reg <= K_LAST))
        else $error("ring walk index out of range");

    // a result is loaded only once the previous one has left or is leaving
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten while still pending");
`endif

endmodule

`default_nettype wire
